// ===== hdl/smsgt_pkg.sv =====
package smsgt_pkg;

   // Tap channel selection
   typedef enum logic [1:0] {
      MODE_LEFT   = 2'd0,
      MODE_RIGHT  = 2'd1,
      MODE_MIXED  = 2'd2,
      MODE_STEREO = 2'd3
   } chan_mode_type;

   // Register indexes on the csr port
   localparam int unsigned CsrIndexWidth = 4;
   localparam logic [CsrIndexWidth-1:0] CSR_NET_COPY_ENABLE = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CHANNEL_MODE    = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RECORD_ENABLE   = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SILENCE_LIMIT   = 4'd3;

   localparam int unsigned CsrDataWidth = 24;

   typedef struct packed {
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic               last_source;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] mixed_left;
      logic signed [15:0] mixed_right;
      logic               net_valid;
      logic signed [15:0] net_first;
      logic signed [15:0] net_second;
      logic               file_valid;
      logic signed [15:0] file_first;
      logic signed [15:0] file_second;
      logic               recording_active;
   } rsp_item_type;

   // One tap sample: mono in first, or left/right in stereo
   typedef struct packed {
      logic signed [15:0] first;
      logic signed [15:0] second;
   } tap_pair_type;

   // Recorder register writes
   typedef struct packed {
      logic                    rec_wr;
      logic                    rec_val;
      logic                    lim_wr;
      logic [CsrDataWidth-1:0] lim_val;
   } gate_cfg_type;

endpackage

// ===== hdl/stereo_mixer_silence_gated_tap.sv =====
// Stereo mixer with network tap and silence-gated file tap.
// req channel: one item per source sample of a frame (left_in, right_in,
//   last_source). The item with last_source set closes the frame.
// rsp channel: one item per closed frame with the saturated mix, the network
//   tap (when enabled) and the file tap (when recording writes this frame).
// csr channel: register writes, csr_ready is always high; write only while
//   no frame item is in flight. 0 net copy enable, 1 channel mode,
//   2 record enable, 3 silence limit; other indexes are ignored.
// An accepted item is held in the input register; the result of a closing
//   item is loaded from there into the output register, where rsp_valid
//   rises and the result waits until it is taken.
// Throughput: one item per cycle while req_stall is low. Per item: one 32-bit
//   add and a saturate/compare step between the input and result registers.
// Stall: a stalled result holds in the output register; the input register
//   still drains items that do not close a frame, and req_stall rises only
//   when a closing item waits for a full output register.
// Reset: synchronous; clears the valid flags, tap and recorder registers,
//   accumulators and the silence count; both channels come up empty.
module stereo_mixer_silence_gated_tap (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  smsgt_pkg::req_item_type                 req_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output smsgt_pkg::rsp_item_type                 rsp_item,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [smsgt_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [smsgt_pkg::CsrDataWidth-1:0]      csr_data
);
   import smsgt_pkg::*;

   // Input register
   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff, s1_item_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   // Tap registers
   logic          net_en_ff, net_en_in;
   chan_mode_type mode_ff, mode_in;

   logic          csr_wr;
   gate_cfg_type  gate_cfg;

   logic          out_free;
   logic          s1_go;
   logic          frame_go;
   logic          s1_load;

   logic signed [15:0] sat_left, sat_right;
   logic          silent;
   logic          file_ok;
   logic          running_next;
   tap_pair_type  net_pair, file_pair;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // Flow control: non-closing items always drain, closing items need room
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_item_ff.last_source || out_free);
   assign frame_go  = s1_go && s1_item_ff.last_source;
   assign s1_load   = !s1_valid_ff || s1_go;
   assign req_stall = !s1_load;

   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;
   assign s1_item_in  = (s1_load && req_valid) ? req_item : s1_item_ff;

   // Register writes
   always_comb begin
      net_en_in = net_en_ff;
      mode_in   = mode_ff;
      gate_cfg  = '0;
      gate_cfg.rec_val = csr_data[0];
      gate_cfg.lim_val = csr_data;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_NET_COPY_ENABLE: net_en_in       = csr_data[0];
            CSR_CHANNEL_MODE:    mode_in         = chan_mode_type'(csr_data[1:0]);
            CSR_RECORD_ENABLE:   gate_cfg.rec_wr = 1'b1;
            CSR_SILENCE_LIMIT:   gate_cfg.lim_wr = 1'b1;
            default: begin
               net_en_in = net_en_ff;
            end
         endcase
      end
   end

   smsgt_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_go),
      .item      (s1_item_ff),
      .sat_left  (sat_left),
      .sat_right (sat_right)
   );

   assign silent = (sat_left == 16'sd0) && (sat_right == 16'sd0);

   smsgt_gate u_gate (
      .clock        (clock),
      .reset        (reset),
      .cfg          (gate_cfg),
      .frame_go     (frame_go),
      .silent       (silent),
      .file_ok      (file_ok),
      .running_next (running_next)
   );

   smsgt_tap u_net_tap (
      .mode   (mode_ff),
      .enable (net_en_ff),
      .left   (sat_left),
      .right  (sat_right),
      .pair   (net_pair)
   );

   smsgt_tap u_file_tap (
      .mode   (mode_ff),
      .enable (file_ok),
      .left   (sat_left),
      .right  (sat_right),
      .pair   (file_pair)
   );

   // Result register load
   always_comb begin
      rsp_item_in = rsp_item_ff;
      if (frame_go) begin
         rsp_item_in.mixed_left       = sat_left;
         rsp_item_in.mixed_right      = sat_right;
         rsp_item_in.net_valid        = net_en_ff;
         rsp_item_in.net_first        = net_pair.first;
         rsp_item_in.net_second       = net_pair.second;
         rsp_item_in.file_valid       = file_ok;
         rsp_item_in.file_first       = file_pair.first;
         rsp_item_in.file_second      = file_pair.second;
         rsp_item_in.recording_active = running_next;
      end
   end

   assign rsp_valid_in = frame_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         net_en_ff    <= 1'b0;
         mode_ff      <= MODE_LEFT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         net_en_ff    <= net_en_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hdl/smsgt_accum.sv =====
module smsgt_accum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  smsgt_pkg::req_item_type    item,
   output logic signed [15:0]         sat_left,
   output logic signed [15:0]         sat_right
);
   import smsgt_pkg::*;

   logic [31:0] acc_l_ff, acc_l_in;
   logic [31:0] acc_r_ff, acc_r_in;
   logic [31:0] sum_l, sum_r;

   function automatic logic signed [15:0] sat16(input logic [31:0] v);
      logic signed [15:0] res;
      if (v[31] && (v[30:15] != 16'hFFFF)) begin
         res = 16'sh8000;
      end else if (!v[31] && (v[30:15] != 16'h0000)) begin
         res = 16'sh7FFF;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   // 32-bit wrap-around accumulation
   assign sum_l = acc_l_ff + {{16{item.left_in[15]}}, item.left_in};
   assign sum_r = acc_r_ff + {{16{item.right_in[15]}}, item.right_in};

   assign sat_left  = sat16(sum_l);
   assign sat_right = sat16(sum_r);

   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (go) begin
         acc_l_in = item.last_source ? 32'd0 : sum_l;
         acc_r_in = item.last_source ? 32'd0 : sum_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_l_ff <= 32'd0;
         acc_r_ff <= 32'd0;
      end else begin
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
   end

endmodule

// ===== hdl/smsgt_tap.sv =====
module smsgt_tap (
   input  smsgt_pkg::chan_mode_type  mode,
   input  logic                      enable,
   input  logic signed [15:0]        left,
   input  logic signed [15:0]        right,
   output smsgt_pkg::tap_pair_type   pair
);
   import smsgt_pkg::*;

   logic signed [16:0] pair_sum;
   logic signed [16:0] pair_adj;
   logic signed [16:0] avg;

   // (L+R)/2 toward zero: bias negative sums by one before the shift
   assign pair_sum = 17'(left) + 17'(right);
   assign pair_adj = pair_sum + {16'd0, pair_sum[16]};
   assign avg      = pair_adj >>> 1;

   always_comb begin
      pair = '0;
      if (enable) begin
         unique case (mode)
            MODE_LEFT: begin
               pair.first = left;
            end
            MODE_RIGHT: begin
               pair.first = right;
            end
            MODE_MIXED: begin
               pair.first = avg[15:0];
            end
            MODE_STEREO: begin
               pair.first  = left;
               pair.second = right;
            end
            default: begin
               pair = '0;
            end
         endcase
      end
   end

endmodule

// ===== hdl/smsgt_gate.sv =====
module smsgt_gate (
   input  logic                      clock,
   input  logic                      reset,
   input  smsgt_pkg::gate_cfg_type   cfg,
   input  logic                      frame_go,
   input  logic                      silent,
   output logic                      file_ok,
   output logic                      running_next
);
   import smsgt_pkg::*;

   logic                    rec_en_ff, rec_en_in;
   logic [CsrDataWidth-1:0] limit_ff, limit_in;
   logic [CsrDataWidth-1:0] count_ff, count_in;
   logic                    running_ff, running_in;

   logic                    frame_write;
   logic                    frame_running;
   logic [CsrDataWidth-1:0] frame_count;

   // Frame decision
   always_comb begin
      frame_write   = 1'b0;
      frame_running = running_ff;
      frame_count   = count_ff;
      if (rec_en_ff) begin
         if (!silent) begin
            frame_running = 1'b1;
            frame_write   = 1'b1;
            frame_count   = '0;
         end else if (limit_ff == '0) begin
            frame_write = 1'b1;
            frame_count = '0;
         end else if (count_ff < limit_ff) begin
            frame_write = 1'b1;
            frame_count = count_ff + 1'b1;
         end else begin
            frame_running = 1'b0;
         end
      end
   end

   assign running_next = frame_running;
   assign file_ok      = frame_write && frame_running;

   always_comb begin
      rec_en_in  = rec_en_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      running_in = running_ff;
      priority if (cfg.rec_wr) begin
         rec_en_in  = cfg.rec_val;
         running_in = cfg.rec_val;
         count_in   = '0;
      end else if (cfg.lim_wr) begin
         limit_in = cfg.lim_val;
         count_in = '0;
      end else if (frame_go) begin
         count_in   = frame_count;
         running_in = frame_running;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_en_ff  <= 1'b0;
         limit_ff   <= '0;
         count_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         rec_en_ff  <= rec_en_in;
         limit_ff   <= limit_in;
         count_ff   <= count_in;
         running_ff <= running_in;
      end
   end

endmodule

// ===== test/mixer_frame_checker.sv =====
module mixer_frame_checker
   import smsgt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_item_type             req_item,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output int                       mismatches,
   output int                       frames_outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_MIN = -32768;
   localparam int SAMPLE_MAX = 32767;

   // register copies
   logic                    net_copy_on;
   chan_mode_type           tap_mode;
   logic                    record_on;
   logic [CsrDataWidth-1:0] silence_max;

   // mixer state
   logic [31:0]             left_sum;
   logic [31:0]             right_sum;
   logic [23:0]             silent_frames;
   logic                    recorder_on;

   rsp_item_type            expected_frames[$];

   initial mismatches = 0;
   initial frames_outstanding = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t frame check: %s", $realtime, what);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   // wrapped 32-bit sum saturated to a 16-bit sample
   function automatic logic signed [15:0] clamp16(input logic [31:0] acc);
      logic signed [31:0] s;
      s = acc;
      if (s < SAMPLE_MIN) begin
         s = SAMPLE_MIN;
      end else if (s > SAMPLE_MAX) begin
         s = SAMPLE_MAX;
      end
      return s[15:0];
   endfunction

   function automatic tap_pair_type select_tap(input logic signed [15:0] l,
                                               input logic signed [15:0] r);
      tap_pair_type t;
      int           avg;
      t = '0;
      case (tap_mode)
         MODE_LEFT:   t.first = l;
         MODE_RIGHT:  t.first = r;
         MODE_MIXED: begin
            // integer divide truncates toward zero
            avg = l;
            avg = (avg + r) / 2;
            t.first = avg[15:0];
         end
         default: begin
            t.first  = l;
            t.second = r;
         end
      endcase
      return t;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type      frame;
      rsp_item_type      want;
      tap_pair_type      t;
      logic signed [15:0] l;
      logic signed [15:0] r;
      logic              write_file;

      if (reset) begin
         net_copy_on   = 1'b0;
         tap_mode      = MODE_LEFT;
         record_on     = 1'b0;
         silence_max   = '0;
         left_sum      = '0;
         right_sum     = '0;
         silent_frames = '0;
         recorder_on   = 1'b0;
         expected_frames.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NET_COPY_ENABLE: net_copy_on = csr_data[0];
               CSR_CHANNEL_MODE:    tap_mode = chan_mode_type'(csr_data[1:0]);
               CSR_RECORD_ENABLE: begin
                  record_on     = csr_data[0];
                  recorder_on   = csr_data[0];
                  silent_frames = '0;
               end
               CSR_SILENCE_LIMIT: begin
                  silence_max   = csr_data;
                  silent_frames = '0;
               end
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               report_mismatch("result with no frame pending");
            end else begin
               want = expected_frames.pop_front();
               compare_field("mixed_left", rsp_item.mixed_left, want.mixed_left);
               compare_field("mixed_right", rsp_item.mixed_right, want.mixed_right);
               compare_field("net_valid", 16'(rsp_item.net_valid),
                             16'(want.net_valid));
               compare_field("net_first", rsp_item.net_first, want.net_first);
               compare_field("net_second", rsp_item.net_second, want.net_second);
               compare_field("file_valid", 16'(rsp_item.file_valid),
                             16'(want.file_valid));
               compare_field("file_first", rsp_item.file_first, want.file_first);
               compare_field("file_second", rsp_item.file_second, want.file_second);
               compare_field("recording_active", 16'(rsp_item.recording_active),
                             16'(want.recording_active));
            end
         end

         if (req_valid && !req_stall) begin
            left_sum  = left_sum + {{16{req_item.left_in[15]}}, req_item.left_in};
            right_sum = right_sum + {{16{req_item.right_in[15]}}, req_item.right_in};
            if (req_item.last_source) begin
               frame      = '0;
               write_file = 1'b0;
               l = clamp16(left_sum);
               r = clamp16(right_sum);
               left_sum  = '0;
               right_sum = '0;
               frame.mixed_left  = l;
               frame.mixed_right = r;
               if (net_copy_on) begin
                  t = select_tap(l, r);
                  frame.net_valid  = 1'b1;
                  frame.net_first  = t.first;
                  frame.net_second = t.second;
               end
               if (record_on) begin
                  if (l == 0 && r == 0) begin
                     if (silence_max == 0) begin
                        write_file    = 1'b1;
                        silent_frames = '0;
                     end else if (silent_frames < silence_max) begin
                        write_file    = 1'b1;
                        silent_frames = silent_frames + 1'b1;
                     end else begin
                        recorder_on = 1'b0;
                     end
                  end else begin
                     recorder_on   = 1'b1;
                     write_file    = 1'b1;
                     silent_frames = '0;
                  end
                  if (write_file && recorder_on) begin
                     t = select_tap(l, r);
                     frame.file_valid  = 1'b1;
                     frame.file_first  = t.first;
                     frame.file_second = t.second;
                  end
               end
               frame.recording_active = recorder_on;
               expected_frames.insert(expected_frames.size(), frame);
            end
         end
      end
      frames_outstanding <= expected_frames.size();
   end

endmodule

// ===== test/tb_top.sv =====
module tb_top;

   import smsgt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_MIN = -32768;
   localparam int SAMPLE_MAX = 32767;
   // index outside the register map, all bits set; the block ignores it
   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED = 4'hF;
   localparam int PHASES            = 8;
   localparam int SOURCES_PER_PHASE = 78;

   // random frame flavors
   typedef enum int {
      FRAME_ZERO,
      FRAME_CANCEL,
      FRAME_EXTREME,
      FRAME_TINY,
      FRAME_NOISE
   } frame_kind_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_item_type             req_item;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_item_type             rsp_item;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   int mismatches;
   int frames_outstanding;

   // random gaps on both sides; off in the last phase
   bit idling_on;
   int phase_sources;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stereo_mixer_silence_gated_tap dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   mixer_frame_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_item           (req_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item           (rsp_item),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .frames_outstanding (frames_outstanding)
   );

   // Result side back-pressure: random stall bursts separated by quiet
   // stretches, each length drawn at random.
   always @(negedge clock) begin : rsp_backpressure
      int stall_left;
      int quiet_left;
      if (reset || !idling_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         quiet_left = 0;
      end else begin
         if (stall_left == 0 && quiet_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
               stall_left = $urandom_range(1, 16);
            end else begin
               quiet_left = $urandom_range(1, 40);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            quiet_left--;
         end
      end
   end

   function automatic req_item_type source_sample(input int l, input int r,
                                                  input bit last);
      req_item_type it;
      it.left_in     = l[15:0];
      it.right_in    = r[15:0];
      it.last_source = last;
      return it;
   endfunction

   // One source item. Called at a falling edge, returns at the falling edge
   // after acceptance. Valid stays high into the next item unless a gap
   // is drawn, so valid is never dropped and raised in the same step.
   task automatic send_source(input req_item_type it);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      phase_sources++;
   endtask

   // Hold the sender until every frame has come back, then let the input and
   // result registers settle so non-closing items are absorbed too.
   task automatic drain_frames();
      req_valid <= 1'b0;
      while (frames_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // csr valid stays high across back-to-back writes; caller group lowers it
   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic net_on, input chan_mode_type mode,
                                 input logic rec_on,
                                 input logic [CsrDataWidth-1:0] limit);
      write_csr(CSR_NET_COPY_ENABLE, CsrDataWidth'(net_on));
      write_csr(CSR_CHANNEL_MODE, CsrDataWidth'(mode));
      write_csr(CSR_RECORD_ENABLE, CsrDataWidth'(rec_on));
      write_csr(CSR_SILENCE_LIMIT, limit);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // A frame of random flavor. Silent frames (all zero or cancelling pairs)
   // are common so that the silence gate counts up, stops and restarts.
   task automatic send_random_frame();
      int             n;
      int             pick;
      int             pl;
      int             pr;
      frame_kind_type kind;
      req_item_type   it;
      pl = 0;
      pr = 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         kind = FRAME_ZERO;
      end else if (pick == 3) begin
         kind = FRAME_CANCEL;
         n = 2 * $urandom_range(1, 3);
      end else if (pick == 4) begin
         kind = FRAME_EXTREME;
      end else if (pick == 5) begin
         kind = FRAME_TINY;
      end else begin
         kind = FRAME_NOISE;
      end
      for (int i = 0; i < n; i++) begin
         it = '0;
         it.last_source = (i == n - 1);
         case (kind)
            FRAME_ZERO: ;
            FRAME_CANCEL: begin
               // sample then its negation; -32768 has no negation, so skip it
               if (i % 2 == 0) begin
                  pl = int'($urandom_range(0, 65534)) - SAMPLE_MAX;
                  pr = int'($urandom_range(0, 65534)) - SAMPLE_MAX;
                  it.left_in  = pl[15:0];
                  it.right_in = pr[15:0];
               end else begin
                  it.left_in  = 16'(-pl);
                  it.right_in = 16'(-pr);
               end
            end
            FRAME_EXTREME: begin
               it.left_in  = 16'($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
               it.right_in = 16'($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
            end
            FRAME_TINY: begin
               it.left_in  = 16'(int'($urandom_range(0, 6)) - 3);
               it.right_in = 16'(int'($urandom_range(0, 6)) - 3);
            end
            default: begin
               it.left_in  = 16'($urandom_range(0, 65535));
               it.right_in = 16'($urandom_range(0, 65535));
            end
         endcase
         send_source(it);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      idling_on = 1'b1;
      phase_sources = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: both taps off
      send_source(source_sample(100, -200, 1'b1));
      drain_frames();

      // mixed mode, recording, two silent frames allowed
      apply_settings(1'b1, MODE_MIXED, 1'b1, 24'd2);
      write_csr(CSR_UNMAPPED, '1);
      csr_valid <= 1'b0;
      @(negedge clock);

      // full scale of opposite sign: average -1/2 truncates to 0
      send_source(source_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
      send_source(source_sample(SAMPLE_MIN, SAMPLE_MIN, 1'b1));
      // saturation at both ends
      send_source(source_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
      send_source(source_sample(1, 1, 1'b1));
      send_source(source_sample(SAMPLE_MIN, SAMPLE_MIN, 1'b0));
      send_source(source_sample(-1, -1, 1'b1));
      // negative odd average rounds toward zero
      send_source(source_sample(-3, 0, 1'b1));
      send_source(source_sample(21845, -21846, 1'b1));
      // silent frames: two recorded, the third stops the recorder
      repeat (3) send_source(source_sample(0, 0, 1'b1));
      // silent by cancellation while stopped
      send_source(source_sample(5, -5, 1'b0));
      send_source(source_sample(-5, 5, 1'b1));
      // non-silent restarts recording, then one silent frame is recorded
      send_source(source_sample(1, 0, 1'b1));
      send_source(source_sample(0, 0, 1'b1));

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_frames();
         idling_on = (phase != PHASES - 1);
         case (phase)
            0: apply_settings(1'b1, MODE_LEFT, 1'b1, 24'd0);
            1: apply_settings(1'b1, MODE_RIGHT, 1'b1, 24'd1);
            2: apply_settings(1'b0, MODE_MIXED, 1'b1, 24'd3);
            3: apply_settings(1'b1, MODE_STEREO, 1'b1, 24'hFFFFFF);
            4: apply_settings(1'b1, MODE_STEREO, 1'b0, 24'd2);
            default: apply_settings(1'($urandom_range(0, 1)),
                                    chan_mode_type'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1)),
                                    24'($urandom_range(0, 4)));
         endcase
         phase_sources = 0;
         while (phase_sources < SOURCES_PER_PHASE) begin
            send_random_frame();
            // now and then let the whole pipe empty mid-phase
            if ($urandom_range(0, 39) == 0) begin
               drain_frames();
            end
         end
      end

      drain_frames();
      if (mismatches == 0) begin
         $display("stereo_mixer_silence_gated_tap: match");
      end else begin
         $display("stereo_mixer_silence_gated_tap: mismatch");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #(20_000_000);
      $display("stereo_mixer_silence_gated_tap: mismatch");
      $finish;
   end

endmodule
